/* hdl/obcp_pkg.sv */
// Package for the oriented box contact point unit: payload structs, register
// indexes, widths and a saturation helper. No dependencies.
`timescale 1ns / 1ps
package obcp_pkg;
	localparam int CB = 20;
	localparam int CF = 12;
	localparam int AF = 18;
	localparam int AB = AF + 2;
	localparam int REG_W = 3 * CB;
	localparam int IDX_W = 3;
	localparam int PW = CB + 2 + AB;   // projection width
	localparam int SW = CB + 2;        // clamped coordinate, Q(CF+1)
	localparam int DW = SW + AB + 2;   // surface offset sum

	localparam logic [IDX_W-1:0] REG_CENTRE = 3'd0;
	localparam logic [IDX_W-1:0] REG_VEL    = 3'd1;
	localparam logic [IDX_W-1:0] REG_SPIN   = 3'd2;
	localparam logic [IDX_W-1:0] REG_AX0    = 3'd3;
	localparam logic [IDX_W-1:0] REG_AX1    = 3'd4;
	localparam logic [IDX_W-1:0] REG_AX2    = 3'd5;
	localparam logic [IDX_W-1:0] REG_EXT    = 3'd6;

	localparam logic [2:0] KIND_NONE   = 3'd0;
	localparam logic [2:0] KIND_INSIDE = 3'd1;
	localparam logic [2:0] KIND_VERTEX = 3'd2;
	localparam logic [2:0] KIND_EDGE   = 3'd3;
	localparam logic [2:0] KIND_FACE   = 3'd4;

	typedef struct packed {
		logic signed [CB-1:0] grain_x;
		logic signed [CB-1:0] grain_y;
		logic signed [CB-1:0] grain_z;
		logic [CB-2:0]        grain_radius;
	} grain_t;

	typedef struct packed {
		logic                 contact_found;
		logic                 grain_inside;
		logic [2:0]           contact_kind;
		logic signed [CB-1:0] point_x;
		logic signed [CB-1:0] point_y;
		logic signed [CB-1:0] point_z;
		logic signed [CB-1:0] surface_vel_x;
		logic signed [CB-1:0] surface_vel_y;
		logic signed [CB-1:0] surface_vel_z;
	} contact_t;

	typedef struct packed {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] z;
	} vec_t;

	function automatic logic signed [CB-1:0] sat_c(input logic signed [CB+2:0] v);
		logic signed [CB+2:0] hi;
		logic signed [CB+2:0] lo;
		hi = (CB+3)'((1 << (CB-1)) - 1);
		lo = -(CB+3)'(1 << (CB-1));
		if (v > hi) return hi[CB-1:0];
		if (v < lo) return lo[CB-1:0];
		return v[CB-1:0];
	endfunction
endpackage

/* hdl/obcp_stage.sv */
// Pipeline stage valid bit with stall handshake; gives the load enable for
// the data registers of its stage. No dependencies.
`timescale 1ns / 1ps
module obcp_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output logic load
);
	logic valid_q;
	assign in_ready = !valid_q || out_ready;
	assign load = in_valid && in_ready;
	assign out_valid = valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (in_ready) valid_q <= in_valid;
	end
endmodule

/* hdl/oriented_box_contact_point_unit.sv */
// Oriented box contact point unit: top level, six pipeline stages.
// Throughput: one item per cycle unless out_ready stalls; ready passes back through all stages in the same cycle.
// Reset: arst_n clears the valid bits and all box registers to zero.
// Uses obcp_pkg and obcp_stage.
`timescale 1ns / 1ps
module oriented_box_contact_point_unit import obcp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  grain_t           in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output contact_t         out_data
);
	logic [REG_W-1:0] regs_q [7];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 7; i++) regs_q[i] <= '0;
		end else if (cfg_we && cfg_index <= REG_EXT) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	logic signed [CB-1:0] ctr [3], vel [3], spin [3];
	logic signed [AB-1:0] ax [3][3];
	logic [CB-1:0] ext [3];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			ctr[j]  = regs_q[REG_CENTRE][j*CB +: CB];
			vel[j]  = regs_q[REG_VEL][j*CB +: CB];
			spin[j] = regs_q[REG_SPIN][j*CB +: CB];
			ext[j]  = regs_q[REG_EXT][j*CB +: CB];
			ax[0][j] = regs_q[REG_AX0][j*AB +: AB];
			ax[1][j] = regs_q[REG_AX1][j*AB +: AB];
			ax[2][j] = regs_q[REG_AX2][j*AB +: AB];
		end
	end

	// stage 1: offsets
	logic v1, r1, ld1;
	logic signed [CB:0] dr1 [3];
	always_comb begin
		dr1[0] = (CB+1)'(in_data.grain_x) - (CB+1)'(ctr[0]);
		dr1[1] = (CB+1)'(in_data.grain_y) - (CB+1)'(ctr[1]);
		dr1[2] = (CB+1)'(in_data.grain_z) - (CB+1)'(ctr[2]);
	end
	obcp_stage u_s1 (.clk, .arst_n, .in_valid, .in_ready,
		.out_valid(v1), .out_ready(r1), .load(ld1));
	logic signed [CB:0] dr_s1 [3];
	logic [CB-2:0] rad_s1;
	always_ff @(posedge clk) begin
		if (ld1) begin
			for (int j = 0; j < 3; j++) dr_s1[j] <= dr1[j];
			rad_s1 <= in_data.grain_radius;
		end
	end

	// stage 2: nine products
	localparam int MW = CB + 1 + AB;
	logic v2, r2, ld2;
	logic signed [MW-1:0] m [3][3];
	always_comb begin
		for (int k = 0; k < 3; k++)
			for (int j = 0; j < 3; j++)
				m[k][j] = MW'(dr_s1[j]) * MW'(ax[k][j]);
	end
	obcp_stage u_s2 (.clk, .arst_n, .in_valid(v1), .in_ready(r1),
		.out_valid(v2), .out_ready(r2), .load(ld2));
	logic signed [MW-1:0] m_s2 [3][3];
	logic [CB-2:0] rad_s2;
	always_ff @(posedge clk) begin
		if (ld2) begin
			for (int k = 0; k < 3; k++)
				for (int j = 0; j < 3; j++)
					m_s2[k][j] <= m[k][j];
			rad_s2 <= rad_s1;
		end
	end

	// stage 3: projections, slab tests, clamp
	logic v3, r3, ld3;
	logic signed [PW-1:0] p [3];
	logic [PW:0] mag2, half2, reach2;
	logic signed [SW-1:0] s3 [3];
	logic signed [PW:0] rs;
	logic ins3, far3;
	logic [1:0] nout;
	logic [2:0] kind3;
	always_comb begin
		ins3 = 1'b1; far3 = 1'b0; nout = '0;
		mag2 = '0; half2 = '0; reach2 = '0; rs = '0;
		for (int k = 0; k < 3; k++) begin
			p[k] = PW'(m_s2[k][0]) + PW'(m_s2[k][1]) + PW'(m_s2[k][2]);
			mag2 = (p[k] < 0) ? (PW+1)'(-(PW+1)'(p[k])) << 1 : (PW+1)'(p[k]) << 1;
			half2 = (PW+1)'(ext[k]) << AF;
			reach2 = ((PW+1)'(ext[k]) + ((PW+1)'(rad_s2) << 1)) << AF;
			rs = ((PW+1)'(p[k]) + (PW+1)'(1 << (AF-2))) >>> (AF-1);
			if (mag2 > half2) begin
				ins3 = 1'b0;
				nout = nout + 2'd1;
				s3[k] = p[k][PW-1] ? -SW'(ext[k]) : SW'(ext[k]);
			end else begin
				s3[k] = rs[SW-1:0];
			end
			if (mag2 > reach2) far3 = 1'b1;
		end
		case (nout)
			2'd3: kind3 = KIND_VERTEX;
			2'd2: kind3 = KIND_EDGE;
			default: kind3 = KIND_FACE;
		endcase
	end
	obcp_stage u_s3 (.clk, .arst_n, .in_valid(v2), .in_ready(r2),
		.out_valid(v3), .out_ready(r3), .load(ld3));
	logic signed [SW-1:0] s_s3 [3];
	logic ins_s3, far_s3;
	logic [2:0] kind_s3;
	always_ff @(posedge clk) begin
		if (ld3) begin
			for (int k = 0; k < 3; k++) s_s3[k] <= s3[k];
			ins_s3 <= ins3;
			far_s3 <= far3;
			kind_s3 <= kind3;
		end
	end

	// stage 4: surface offset
	localparam int OW = CB + 3;
	logic v4, r4, ld4;
	logic signed [DW-1:0] acc;
	logic signed [OW-1:0] drv4 [3];
	always_comb begin
		acc = '0;
		for (int j = 0; j < 3; j++) begin
			acc = DW'(s_s3[0]) * DW'(ax[0][j]) + DW'(s_s3[1]) * DW'(ax[1][j])
				+ DW'(s_s3[2]) * DW'(ax[2][j]) + DW'(1 << AF);
			acc = acc >>> (AF + 1);
			drv4[j] = acc[OW-1:0];
		end
	end
	obcp_stage u_s4 (.clk, .arst_n, .in_valid(v3), .in_ready(r3),
		.out_valid(v4), .out_ready(r4), .load(ld4));
	logic signed [OW-1:0] drv_s4 [3];
	logic ins_s4, far_s4;
	logic [2:0] kind_s4;
	always_ff @(posedge clk) begin
		if (ld4) begin
			for (int j = 0; j < 3; j++) drv_s4[j] <= drv4[j];
			ins_s4 <= ins_s3;
			far_s4 <= far_s3;
			kind_s4 <= kind_s3;
		end
	end

	// stage 5: cross products
	localparam int XW = CB + OW + 2;
	logic v5, r5, ld5;
	logic signed [XW-1:0] xp;
	logic signed [XW-CF-1:0] cr5 [3];
	always_comb begin
		xp = '0;
		for (int j = 0; j < 3; j++) begin
			xp = XW'(spin[(j+1)%3]) * XW'(drv_s4[(j+2)%3])
				- XW'(spin[(j+2)%3]) * XW'(drv_s4[(j+1)%3]) + XW'(1 << (CF-1));
			xp = xp >>> CF;
			cr5[j] = xp[XW-CF-1:0];
		end
	end
	obcp_stage u_s5 (.clk, .arst_n, .in_valid(v4), .in_ready(r4),
		.out_valid(v5), .out_ready(r5), .load(ld5));
	logic signed [OW-1:0] drv_s5 [3];
	logic signed [XW-CF-1:0] cr_s5 [3];
	logic ins_s5, far_s5;
	logic [2:0] kind_s5;
	always_ff @(posedge clk) begin
		if (ld5) begin
			for (int j = 0; j < 3; j++) begin
				drv_s5[j] <= drv_s4[j];
				cr_s5[j] <= cr5[j];
			end
			ins_s5 <= ins_s4;
			far_s5 <= far_s4;
			kind_s5 <= kind_s4;
		end
	end

	// stage 6: add, saturate, format
	logic ld6;
	contact_t res;
	contact_t res_s6;
	logic signed [CB-1:0] pt [3], sv [3];
	logic signed [XW-CF:0] vs;
	always_comb begin
		vs = '0;
		for (int j = 0; j < 3; j++) begin
			pt[j] = sat_c((CB+3)'(ctr[j]) + (CB+3)'(drv_s5[j]));
			vs = (XW-CF+1)'(vel[j]) + (XW-CF+1)'(cr_s5[j]);
			if (vs > (XW-CF+1)'((1 << (CB-1)) - 1)) sv[j] = CB'((1 << (CB-1)) - 1);
			else if (vs < -(XW-CF+1)'(1 << (CB-1))) sv[j] = CB'(-(1 << (CB-1)));
			else sv[j] = vs[CB-1:0];
		end
		res = '0;
		if (ins_s5) begin
			res.grain_inside = 1'b1;
			res.contact_kind = KIND_INSIDE;
		end else if (!far_s5) begin
			res.contact_found = 1'b1;
			res.contact_kind = kind_s5;
			res.point_x = pt[0]; res.point_y = pt[1]; res.point_z = pt[2];
			res.surface_vel_x = sv[0]; res.surface_vel_y = sv[1]; res.surface_vel_z = sv[2];
		end
	end
	obcp_stage u_s6 (.clk, .arst_n, .in_valid(v5), .in_ready(r5),
		.out_valid, .out_ready, .load(ld6));
	always_ff @(posedge clk) begin
		if (ld6) res_s6 <= res;
	end
	assign out_data = res_s6;
endmodule

/* hdl/obcp_checker.sv */
// Port checker for the oriented box contact point unit, bound to the top level.
// Uses obcp_pkg.
`timescale 1ns / 1ps
module obcp_checker import obcp_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input contact_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.contact_found && out_data.grain_inside)) else $error("flags");
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.contact_found && !out_data.grain_inside
		|-> out_data.contact_kind == KIND_NONE && out_data.point_x == '0) else $error("none");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.contact_found |-> out_data.contact_kind == KIND_VERTEX
		|| out_data.contact_kind == KIND_EDGE || out_data.contact_kind == KIND_FACE)
		else $error("kind");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready) else $error("ready");
endmodule

bind oriented_box_contact_point_unit obcp_checker u_chk (.clk, .arst_n,
	.in_ready, .out_valid, .out_ready, .out_data);

/* tb/oriented_box_contact_point_unit_test.sv */
// Self-checking testbench for the oriented box contact point unit.
// Drives grains against programmed boxes, predicts each contact result and
// compares it with the block output. Uses obcp_pkg and the RTL top level.
`timescale 1ns / 1ps
module oriented_box_contact_point_unit_test;
	import obcp_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	grain_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	contact_t out_data;

	logic [REG_W-1:0] box_regs [0:6];
	contact_t pending_contacts [$];
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int idle_pct = 17;
	int kind_count [0:4];

	oriented_box_contact_point_unit DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic longint fld(input logic [REG_W-1:0] r, input int i);
		logic signed [CB-1:0] v;
		v = r[i*CB +: CB];
		return longint'(v);
	endfunction

	function automatic longint rnd_shift(input longint x, input int n);
		return (x + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic logic [CB-1:0] clip(input longint x);
		longint hi;
		hi = (longint'(1) <<< (CB - 1)) - 1;
		if (x > hi) x = hi;
		if (x < -hi - 1) x = -hi - 1;
		return x[CB-1:0];
	endfunction

	function automatic contact_t closest_point(input grain_t g);
		contact_t c;
		longint dr[3], ax[3][3], ext[3], p[3], s[3], drv[3], ctr[3], gv[3];
		longint rad, mag2, cr;
		int n_out;
		bit in_box, far;
		c = '0;
		n_out = 0;
		in_box = 1;
		far = 0;
		rad = longint'(g.grain_radius);
		gv[0] = longint'(g.grain_x);
		gv[1] = longint'(g.grain_y);
		gv[2] = longint'(g.grain_z);
		for (int j = 0; j < 3; j++) begin
			ctr[j] = fld(box_regs[REG_CENTRE], j);
			ext[j] = longint'(box_regs[REG_EXT][j*CB +: CB]);
			dr[j] = gv[j] - ctr[j];
		end
		for (int k = 0; k < 3; k++)
			for (int j = 0; j < 3; j++)
				ax[k][j] = fld(box_regs[REG_AX0 + k], j);
		for (int k = 0; k < 3; k++) begin
			p[k] = dr[0] * ax[k][0] + dr[1] * ax[k][1] + dr[2] * ax[k][2];
			mag2 = 2 * (p[k] < 0 ? -p[k] : p[k]);
			if (mag2 > (ext[k] <<< AF)) begin
				in_box = 0;
				n_out++;
				s[k] = p[k] < 0 ? -ext[k] : ext[k];
			end else
				s[k] = rnd_shift(p[k], AF - 1);
			if (mag2 > ((ext[k] + 2 * rad) <<< AF)) far = 1;
		end
		if (in_box) begin
			c.grain_inside = 1;
			c.contact_kind = KIND_INSIDE;
			return c;
		end
		if (far) return c;
		for (int j = 0; j < 3; j++)
			drv[j] = rnd_shift(s[0] * ax[0][j] + s[1] * ax[1][j] + s[2] * ax[2][j], AF + 1);
		c.contact_found = 1;
		c.contact_kind = n_out == 3 ? KIND_VERTEX : n_out == 2 ? KIND_EDGE : KIND_FACE;
		for (int j = 0; j < 3; j++) begin
			int a, b;
			a = (j + 1) % 3;
			b = (j + 2) % 3;
			cr = rnd_shift(fld(box_regs[REG_SPIN], a) * drv[b]
				- fld(box_regs[REG_SPIN], b) * drv[a], CF);
			c[(5 - j) * CB +: CB] = clip(ctr[j] + drv[j]);
			c[(2 - j) * CB +: CB] = clip(fld(box_regs[REG_VEL], j) + cr);
		end
		return c;
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		if (idx <= REG_EXT) box_regs[idx] = v;
		@(posedge clk);
	endtask

	task automatic send_grain(input grain_t g);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= g;
		pending_contacts.push_back(closest_point(g));
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending_contacts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_pct);
		if (out_valid && out_ready) begin
			contact_t e;
			results_seen++;
			if (pending_contacts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", out_data);
			end else begin
				e = pending_contacts.pop_front();
				kind_count[e.contact_kind]++;
				if (out_data !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h got %h", e, out_data);
				end
			end
		end
	end

	function automatic logic [REG_W-1:0] vec3(input longint a, input longint b,
		input longint c);
		return {c[CB-1:0], b[CB-1:0], a[CB-1:0]};
	endfunction

	function automatic longint unit_q(input int f);
		return f * (longint'(1) <<< AF) / 100;
	endfunction

	task automatic set_box(input int shape);
		longint e;
		write_reg(REG_CENTRE, shape == 0 ? '0 : vec3($urandom_range(8191) - 4096,
			$urandom_range(8191) - 4096, $urandom_range(8191) - 4096));
		write_reg(REG_VEL, REG_W'({$urandom, $urandom}));
		write_reg(REG_SPIN, shape == 3 ? vec3(-524288, 524287, -524288) :
			vec3($urandom_range(16383) - 8192, $urandom_range(16383) - 8192,
			$urandom_range(16383) - 8192));
		case (shape)
			0, 3: begin
				write_reg(REG_AX0, vec3(1 << AF, 0, 0));
				write_reg(REG_AX1, vec3(0, 1 << AF, 0));
				write_reg(REG_AX2, vec3(0, 0, 1 << AF));
			end
			1: begin
				write_reg(REG_AX0, vec3(unit_q(60), unit_q(80), 0));
				write_reg(REG_AX1, vec3(-unit_q(80), unit_q(60), 0));
				write_reg(REG_AX2, vec3(0, 0, 1 << AF));
			end
			default: begin
				write_reg(REG_AX0, REG_W'({$urandom, $urandom}));
				write_reg(REG_AX1, REG_W'({$urandom, $urandom}));
				write_reg(REG_AX2, REG_W'({$urandom, $urandom}));
			end
		endcase
		e = shape == 3 ? 0 : 8192 + $urandom_range(16383);
		write_reg(REG_EXT, shape == 2 ? REG_W'({$urandom, $urandom}) : vec3(e, e / 2 + 1, e));
		write_reg(3'd7, '1);
	endtask

	function automatic grain_t near_grain();
		grain_t g;
		logic [REG_W-1:0] c;
		c = box_regs[REG_CENTRE];
		g.grain_x = CB'(c[0 +: CB] + $urandom_range(32767) - 16384);
		g.grain_y = CB'(c[CB +: CB] + $urandom_range(32767) - 16384);
		g.grain_z = CB'(c[2*CB +: CB] + $urandom_range(32767) - 16384);
		g.grain_radius = (CB-1)'($urandom_range(12000));
		return g;
	endfunction

	task automatic test_directed;
		grain_t g;
		set_box(0);
		write_reg(REG_EXT, vec3(8192, 8192, 8192));
		send_grain('0);
		send_grain('{4096, 0, 0, 0});
		send_grain('{4097, 0, 0, 1});
		send_grain('{4098, 0, 0, 1});
		send_grain('{6000, 6000, 0, 4000});
		send_grain('{6000, 6000, 6000, 4000});
		send_grain('{-6000, -6000, -6000, 524287});
		send_grain('{-524288, 524287, -524288, 524287});
		send_grain('{524287, -524288, 524287, 0});
		drain();
		write_reg(REG_EXT, '0);
		send_grain('0);
		send_grain('{1, 0, 0, 1});
		g = '{0, 0, 0, 0};
		send_grain(g);
		drain();
		write_reg(REG_EXT, '1);
		write_reg(REG_SPIN, vec3(524287, -524288, 524287));
		send_grain('{524287, 524287, 524287, 0});
		send_grain('{-524288, 5, -524288, 524287});
		drain();
	endtask

	task automatic test_random;
		grain_t g;
		for (int phase = 0; phase < 8; phase++) begin
			set_box(phase % 4);
			idle_pct = (phase == 5) ? 0 : 17;
			for (int i = 0; i < 100; i++) begin
				if ($urandom_range(9) < 8) g = near_grain();
				else g = $bits(grain_t)'({$urandom, $urandom, $urandom});
				send_grain(g);
				if (i == 50 && phase == 2)
					drain();
			end
			drain();
		end
	endtask

	initial begin
		for (int i = 0; i < 7; i++) box_regs[i] = '0;
		for (int i = 0; i < 5; i++) kind_count[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random();
		$display("%0d grains sent, %0d results checked, %0d mismatches", items_sent,
			results_seen, mismatches);
		$display("kinds none/inside/vertex/edge/face: %0d %0d %0d %0d %0d",
			kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4]);
		if (mismatches == 0 && pending_contacts.size() == 0)
			$display("** oriented_box_contact_point_unit: PASSED **");
		else
			$display("** oriented_box_contact_point_unit: FAILED **");
		$finish;
	end

	initial begin
		#2ms;
		$display("** oriented_box_contact_point_unit: FAILED **");
		$finish;
	end
endmodule
